[rtl/bpf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_pkg: shared types and constants of the pi-model branch flow block
// Item layouts, coefficient bundle, pipeline stage numbering and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package bpf_pkg;

  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned CFG_IDX_W    = 8;

  // Pipeline stage numbering of the item path.
  localparam int unsigned ST_CS  = CORDIC_STEPS + 1;
  localparam int unsigned ST_M1  = CORDIC_STEPS + 2;
  localparam int unsigned ST_M2  = CORDIC_STEPS + 3;
  localparam int unsigned ST_R1  = CORDIC_STEPS + 4;
  localparam int unsigned ST_K   = CORDIC_STEPS + 5;
  localparam int unsigned ST_KM  = CORDIC_STEPS + 6;
  localparam int unsigned ST_M3  = CORDIC_STEPS + 7;
  localparam int unsigned ST_M4  = CORDIC_STEPS + 8;
  localparam int unsigned ST_R2  = CORDIC_STEPS + 9;
  localparam int unsigned ST_SUM = CORDIC_STEPS + 10;
  localparam int unsigned ST_OUT = CORDIC_STEPS + 11;
  localparam int unsigned NST    = CORDIC_STEPS + 12;

  localparam logic [39:0] COEF_MAX = 40'h7F_FFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SERIES_R = 8'd0,
    REG_SERIES_X = 8'd1,
    REG_SHUNT_G  = 8'd2,
    REG_SHUNT_B  = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic        [31:0] volt_from;
    logic signed [31:0] angle_from;
    logic        [31:0] volt_to;
    logic signed [31:0] angle_to;
  } in_item_t;

  typedef struct packed {
    logic signed [39:0] p_from_delta;
    logic signed [39:0] q_from_delta;
    logic signed [39:0] p_to_delta;
    logic signed [39:0] q_to_delta;
    logic               error_flag;
  } out_item_t;

  // Branch coefficients derived from the configuration.
  typedef struct packed {
    logic        ready;
    logic        zero;
    logic        sat;
    logic [39:0] g_mag;
    logic        g_neg;
    logic [39:0] b_mag;
    logic        b_neg;
    logic [41:0] ap_mag;
    logic        ap_neg;
    logic [41:0] aq_mag;
    logic        aq_neg;
  } coef_t;

  typedef struct packed {
    logic s1;
    logic s2;
  } mul_en_t;

  // atan(2^-i) as a binary angle, 2^31 = pi.
  function automatic logic [33:0] cordic_atan(input int unsigned i);
    logic [33:0] a;
    case (i)
      0:       a = 34'd536870912;
      1:       a = 34'd316933406;
      2:       a = 34'd167458907;
      3:       a = 34'd85004756;
      4:       a = 34'd42667331;
      5:       a = 34'd21354465;
      6:       a = 34'd10679838;
      7:       a = 34'd5340245;
      8:       a = 34'd2670163;
      9:       a = 34'd1335087;
      10:      a = 34'd667544;
      11:      a = 34'd333772;
      12:      a = 34'd166886;
      13:      a = 34'd83443;
      14:      a = 34'd41722;
      15:      a = 34'd20861;
      16:      a = 34'd10430;
      17:      a = 34'd5215;
      18:      a = 34'd2608;
      19:      a = 34'd1304;
      20:      a = 34'd652;
      21:      a = 34'd326;
      22:      a = 34'd163;
      23:      a = 34'd81;
      24:      a = 34'd41;
      25:      a = 34'd20;
      26:      a = 34'd10;
      27:      a = 34'd5;
      28:      a = 34'd3;
      29:      a = 34'd1;
      30:      a = 34'd1;
      default: a = 34'd0;
    endcase
    return a;
  endfunction

endpackage

[rtl/bpf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_if: valid/ready channels of the branch flow block
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface bpf_in_if import bpf_pkg::*; ;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bpf_out_if import bpf_pkg::*; ;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bpf_cfg_if import bpf_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/bpf_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_mul: two-stage 42 x 64 bit unsigned multiplier
// Four 21 x 32 bit partial products are registered, then summed.
// ----------------------------------------------------------------------------
module bpf_mul import bpf_pkg::*; (
  input  logic          clk_i,
  input  mul_en_t       en_i,
  input  logic [41:0]   a_i,
  input  logic [63:0]   b_i,
  output logic [105:0]  p_o
);

  logic [52:0]  pp00_q, pp01_q, pp10_q, pp11_q;
  logic [105:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      pp00_q <= 53'(a_i[20:0])  * 53'(b_i[31:0]);
      pp01_q <= 53'(a_i[20:0])  * 53'(b_i[63:32]);
      pp10_q <= 53'(a_i[41:21]) * 53'(b_i[31:0]);
      pp11_q <= 53'(a_i[41:21]) * 53'(b_i[63:32]);
    end
    if (en_i.s2) begin
      p_q <= 106'(pp00_q) + (106'(pp01_q) << 32) + (106'(pp10_q) << 21)
           + (106'(pp11_q) << 53);
    end
  end

  assign p_o = p_q;

endmodule

[rtl/bpf_coef.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_coef: configuration registers and series admittance unit
// Holds R, X, G and B and derives g, b and the shunt-augmented self terms
// with a bit-serial restoring divider after reset and after every write.
// ----------------------------------------------------------------------------
module bpf_coef import bpf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bpf_cfg_if.sink   cfg_i,
  output coef_t     coef_o
);

  localparam int unsigned DIV_STEPS = 80;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [7:0] {
    CS_SQR_R = 8'b0000_0001,
    CS_SQR_X = 8'b0000_0010,
    CS_SUM   = 8'b0000_0100,
    CS_DIV   = 8'b0000_1000,
    CS_FIN_A = 8'b0001_0000,
    CS_FIN_B = 8'b0010_0000,
    CS_FIN_C = 8'b0100_0000,
    CS_DONE  = 8'b1000_0000
  } coef_state_e;

  coef_state_e state_q, state_d;

  logic signed [31:0] r_q, x_q, gsh_q, bsh_q;
  logic signed [63:0] rr_q, xx_q;
  logic [63:0]        d_q;
  logic [63:0]        remg_q, remb_q;
  logic [31:0]        numg_q, numb_q;
  logic [39:0]        qg_q, qb_q;
  logic               ovfg_q, ovfb_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [39:0]        g_mag_q, b_mag_q;
  logic               g_neg_q, b_neg_q, sat_q, zero_q;
  logic signed [41:0] ap_q, aq_q;
  logic [41:0]        ap_mag_q, aq_mag_q;
  logic               ap_neg_q, aq_neg_q;

  logic               cfg_wr;
  logic [64:0]        stepg, stepb;
  logic signed [41:0] g_s, b_s;

  // One restoring step: the quotient bit on top of the new remainder.
  function automatic logic [64:0] div_step(input logic [63:0] rem, input logic nb,
                                           input logic [63:0] d);
    logic [63:0] t;
    t = {rem[62:0], nb};
    if (t >= d) begin
      return {1'b1, t - d};
    end
    return {1'b0, t};
  endfunction

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid;

  assign stepg = div_step(remg_q, numg_q[31], d_q);
  assign stepb = div_step(remb_q, numb_q[31], d_q);
  assign g_s   = g_neg_q ? -$signed(42'(g_mag_q)) : $signed(42'(g_mag_q));
  assign b_s   = b_neg_q ? -$signed(42'(b_mag_q)) : $signed(42'(b_mag_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q   <= 32'sd0;
      x_q   <= 32'sd167772;
      gsh_q <= 32'sd0;
      bsh_q <= 32'sd0;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_SERIES_R: r_q   <= $signed(cfg_i.data);
        REG_SERIES_X: x_q   <= $signed(cfg_i.data);
        REG_SHUNT_G:  gsh_q <= $signed(cfg_i.data);
        REG_SHUNT_B:  bsh_q <= $signed(cfg_i.data);
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_SQR_R: state_d = CS_SQR_X;
      CS_SQR_X: state_d = CS_SUM;
      CS_SUM:   state_d = CS_DIV;
      CS_DIV:   if (cnt_q == CNT_LAST) state_d = CS_FIN_A;
      CS_FIN_A: state_d = CS_FIN_B;
      CS_FIN_B: state_d = CS_FIN_C;
      CS_FIN_C: state_d = CS_DONE;
      CS_DONE:  state_d = CS_DONE;
      default:  state_d = CS_SQR_R;
    endcase
    // Any write, even to an unused index, restarts the derivation.
    if (cfg_wr) state_d = CS_SQR_R;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_SQR_R;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == CS_DIV) cnt_q <= cnt_q + CNT_W'(1);
      else                   cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      CS_SQR_R: rr_q <= r_q * r_q;
      CS_SQR_X: xx_q <= x_q * x_q;
      CS_SUM: begin
        d_q    <= 64'(rr_q) + 64'(xx_q);
        remg_q <= '0;
        remb_q <= '0;
        qg_q   <= '0;
        qb_q   <= '0;
        ovfg_q <= 1'b0;
        ovfb_q <= 1'b0;
        numg_q <= r_q[31] ? 32'(-r_q) : 32'(r_q);
        numb_q <= x_q[31] ? 32'(-x_q) : 32'(x_q);
      end
      CS_DIV: begin
        remg_q <= stepg[63:0];
        remb_q <= stepb[63:0];
        qg_q   <= {qg_q[38:0], stepg[64]};
        qb_q   <= {qb_q[38:0], stepb[64]};
        ovfg_q <= ovfg_q | qg_q[39];
        ovfb_q <= ovfb_q | qb_q[39];
        numg_q <= numg_q << 1;
        numb_q <= numb_q << 1;
      end
      CS_FIN_A: begin
        g_mag_q <= (ovfg_q | qg_q[39]) ? COEF_MAX : qg_q;
        b_mag_q <= (ovfb_q | qb_q[39]) ? COEF_MAX : qb_q;
        sat_q   <= ovfg_q | qg_q[39] | ovfb_q | qb_q[39];
        zero_q  <= (d_q == 64'd0);
        g_neg_q <= r_q < 0;
        b_neg_q <= x_q > 0;
      end
      CS_FIN_B: begin
        ap_q <= (g_s <<< 1) + 42'(gsh_q);
        aq_q <= -(b_s <<< 1) - 42'(bsh_q);
      end
      CS_FIN_C: begin
        ap_mag_q <= ap_q[41] ? 42'(-ap_q) : 42'(ap_q);
        aq_mag_q <= aq_q[41] ? 42'(-aq_q) : 42'(aq_q);
        ap_neg_q <= ap_q[41];
        aq_neg_q <= aq_q[41];
      end
      default: ;
    endcase
  end

  assign coef_o.ready  = (state_q == CS_DONE);
  assign coef_o.zero   = zero_q;
  assign coef_o.sat    = sat_q;
  assign coef_o.g_mag  = g_mag_q;
  assign coef_o.g_neg  = g_neg_q;
  assign coef_o.b_mag  = b_mag_q;
  assign coef_o.b_neg  = b_neg_q;
  assign coef_o.ap_mag = ap_mag_q;
  assign coef_o.ap_neg = ap_neg_q;
  assign coef_o.aq_mag = aq_mag_q;
  assign coef_o.aq_neg = aq_neg_q;

endmodule

[rtl/pi_branch_power_flow_residual.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pi_branch_power_flow_residual: pi-model branch power flow contributions
// Streams bus voltage pairs and returns the P and Q amounts at both ends.
// ----------------------------------------------------------------------------
// Usage
//   cfg_i writes R, X, G and B (index 0..3, others are ignored). Each write,
//   and the release of reset, starts the admittance divider; in_i.ready is
//   low while g and b are derived (set-up of the squares and their sum,
//   one quotient bit per cycle in the divide, then the finishing steps).
//   in_i takes one beat per cycle once the coefficients are ready. Each beat
//   gives one beat on out_o after the angle stage, one stage per CORDIC
//   rotation, two passes through the split multipliers with rounding, then
//   sum and saturation. Throughput is one item per cycle; every stage
//   holds its own valid bit and moves up when the next stage is empty or
//   moving, so a stalled out_o keeps its beat while the stages behind it
//   keep filling, and a stalled out_o drops in_i.ready only once the
//   whole pipeline is full.
//   Zero impedance returns the positive limit on all four powers with the
//   error flag; any saturated coefficient or result also sets the flag.
// ----------------------------------------------------------------------------
module pi_branch_power_flow_residual import bpf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpf_cfg_if.sink    cfg_i,
  bpf_in_if.sink     in_i,
  bpf_out_if.source  out_o
);

  localparam logic signed [33:0] ANG_QUARTER = 34'sd1073741824;
  localparam logic signed [33:0] ANG_HALF    = 34'sd2147483648;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [49:0] SUM_MAX     = 50'sd549755813887;
  localparam logic signed [49:0] SUM_MIN     = -50'sd549755813888;

  coef_t coef;

  logic [NST-1:0] v_q, adv;
  logic           in_rdy;

  logic signed [31:0] dz;
  logic signed [33:0] dze, z0;
  logic               neg0;

  logic signed [33:0] cx_q [CORDIC_STEPS+1];
  logic signed [33:0] cy_q [CORDIC_STEPS+1];
  logic signed [33:0] cz_q [CORDIC_STEPS+1];
  logic               cn_q [CORDIC_STEPS+1];
  logic [31:0]        vf_q [ST_K+1];
  logic [31:0]        vt_q [ST_K+1];

  logic [33:0]        cosm_q, sinm_q;
  logic               cosn_q, sinn_q;

  logic [41:0]        a_a  [4];
  logic [63:0]        b_a  [4];
  logic [105:0]       p_a  [4];
  logic [3:0]         sg_a, sga1_q, sga2_q;
  logic signed [41:0] ta_q [4];
  logic signed [42:0] k_q  [4];
  logic [41:0]        km_q [4];
  logic [3:0]         kn_q;
  logic [63:0]        v11_q, v22_q, v12_q;

  logic [41:0]        a_b  [8];
  logic [63:0]        b_b  [8];
  logic [105:0]       p_b  [8];
  logic [7:0]         sg_b, sgb1_q, sgb2_q;
  logic signed [49:0] tb_q [8];
  logic signed [49:0] su_q [4];

  out_item_t          out_q, out_d;
  logic signed [39:0] res [4];
  logic [3:0]         res_sat;

  function automatic logic signed [49:0] round_signed(input logic [105:0] p,
                                                      input logic neg,
                                                      input int unsigned sh);
    logic [105:0] t;
    t = (p + (106'd1 << (sh - 1))) >> sh;
    return neg ? -$signed(t[49:0]) : $signed(t[49:0]);
  endfunction

  bpf_coef u_coef (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .coef_o (coef)
  );

  // Stage advance: a stage takes new data when it is empty or drains.
  always_comb begin
    adv[NST-1] = !v_q[NST-1] || out_o.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_rdy     = adv[0] && coef.ready;
  assign in_i.ready = in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_i.valid && in_rdy;
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Angle difference folded into the right half plane.
  always_comb begin
    dz   = in_i.data.angle_from - in_i.data.angle_to;
    dze  = 34'(dz);
    z0   = dze;
    neg0 = 1'b0;
    if (dze > ANG_QUARTER) begin
      z0   = dze - ANG_HALF;
      neg0 = 1'b1;
    end else if (dze < -ANG_QUARTER) begin
      z0   = dze + ANG_HALF;
      neg0 = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      cx_q[0] <= CORDIC_GAIN;
      cy_q[0] <= 34'sd0;
      cz_q[0] <= z0;
      cn_q[0] <= neg0;
      vf_q[0] <= in_i.data.volt_from;
      vt_q[0] <= in_i.data.volt_to;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    logic signed [33:0] dx, dy, at;
    assign dx = cy_q[k] >>> k;
    assign dy = cx_q[k] >>> k;
    assign at = $signed(cordic_atan(k));
    always_ff @(posedge clk_i) begin
      if (adv[k+1]) begin
        if (cz_q[k] >= 0) begin
          cx_q[k+1] <= cx_q[k] - dx;
          cy_q[k+1] <= cy_q[k] + dy;
          cz_q[k+1] <= cz_q[k] - at;
        end else begin
          cx_q[k+1] <= cx_q[k] + dx;
          cy_q[k+1] <= cy_q[k] - dy;
          cz_q[k+1] <= cz_q[k] + at;
        end
        cn_q[k+1] <= cn_q[k];
      end
    end
  end

  for (genvar k = 1; k <= ST_K; k++) begin : g_volt
    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        vf_q[k] <= vf_q[k-1];
        vt_q[k] <= vt_q[k-1];
      end
    end
  end

  // The fold negates cos and sin; only the sign of each operand moves.
  always_ff @(posedge clk_i) begin
    if (adv[ST_CS]) begin
      cosm_q <= cx_q[CORDIC_STEPS][33] ? 34'(-cx_q[CORDIC_STEPS]) : 34'(cx_q[CORDIC_STEPS]);
      sinm_q <= cy_q[CORDIC_STEPS][33] ? 34'(-cy_q[CORDIC_STEPS]) : 34'(cy_q[CORDIC_STEPS]);
      cosn_q <= cx_q[CORDIC_STEPS][33] ^ cn_q[CORDIC_STEPS];
      sinn_q <= cy_q[CORDIC_STEPS][33] ^ cn_q[CORDIC_STEPS];
    end
  end

  // Products g*cos, g*sin, b*cos, b*sin.
  for (genvar j = 0; j < 4; j++) begin : g_mul_a
    assign a_a[j]  = (j < 2) ? {2'b00, coef.g_mag} : {2'b00, coef.b_mag};
    assign b_a[j]  = (j % 2 == 0) ? 64'(cosm_q) : 64'(sinm_q);
    assign sg_a[j] = ((j < 2) ? coef.g_neg : coef.b_neg) ^
                     ((j % 2 == 0) ? cosn_q : sinn_q);
    bpf_mul u_mul (
      .clk_i (clk_i),
      .en_i  ('{s1: adv[ST_M1], s2: adv[ST_M2]}),
      .a_i   (a_a[j]),
      .b_i   (b_a[j]),
      .p_o   (p_a[j])
    );
    always_ff @(posedge clk_i) begin
      if (adv[ST_R1]) ta_q[j] <= 42'(round_signed(p_a[j], sga2_q[j], 30));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_M1]) sga1_q <= sg_a;
    if (adv[ST_M2]) sga2_q <= sga1_q;
    if (adv[ST_K]) begin
      k_q[0] <= -43'(ta_q[0]) - 43'(ta_q[3]);
      k_q[1] <= -43'(ta_q[1]) + 43'(ta_q[2]);
      k_q[2] <= -43'(ta_q[0]) + 43'(ta_q[3]);
      k_q[3] <=  43'(ta_q[1]) + 43'(ta_q[2]);
    end
    if (adv[ST_KM]) begin
      for (int j = 0; j < 4; j++) begin
        km_q[j] <= k_q[j][42] ? 42'(-k_q[j]) : 42'(k_q[j]);
        kn_q[j] <= k_q[j][42];
      end
      v11_q <= 64'(vf_q[ST_K]) * 64'(vf_q[ST_K]);
      v22_q <= 64'(vt_q[ST_K]) * 64'(vt_q[ST_K]);
      v12_q <= 64'(vf_q[ST_K]) * 64'(vt_q[ST_K]);
    end
  end

  // Even lanes: self term times V^2; odd lanes: mutual term times V1V2.
  for (genvar j = 0; j < 8; j++) begin : g_mul_b
    if (j % 2 == 1) begin : g_mutual
      assign a_b[j]  = km_q[j/2];
      assign b_b[j]  = v12_q;
      assign sg_b[j] = kn_q[j/2];
    end else begin : g_self
      assign a_b[j]  = ((j / 2) % 2 == 0) ? coef.ap_mag : coef.aq_mag;
      assign b_b[j]  = (j < 4) ? v11_q : v22_q;
      assign sg_b[j] = ((j / 2) % 2 == 0) ? coef.ap_neg : coef.aq_neg;
    end
    bpf_mul u_mul (
      .clk_i (clk_i),
      .en_i  ('{s1: adv[ST_M3], s2: adv[ST_M4]}),
      .a_i   (a_b[j]),
      .b_i   (b_b[j]),
      .p_o   (p_b[j])
    );
    always_ff @(posedge clk_i) begin
      if (adv[ST_R2]) tb_q[j] <= round_signed(p_b[j], sgb2_q[j], (j % 2 == 1) ? 60 : 61);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_M3]) sgb1_q <= sg_b;
    if (adv[ST_M4]) sgb2_q <= sgb1_q;
    if (adv[ST_SUM]) begin
      for (int o = 0; o < 4; o++) begin
        su_q[o] <= tb_q[2*o] + tb_q[2*o+1];
      end
    end
    if (adv[ST_OUT]) out_q <= out_d;
  end

  always_comb begin
    for (int o = 0; o < 4; o++) begin
      res_sat[o] = 1'b1;
      if (su_q[o] > SUM_MAX) begin
        res[o] = $signed(COEF_MAX);
      end else if (su_q[o] < SUM_MIN) begin
        res[o] = -$signed(COEF_MAX) - 40'sd1;
      end else begin
        res[o]     = su_q[o][39:0];
        res_sat[o] = 1'b0;
      end
      if (coef.zero) res[o] = $signed(COEF_MAX);
    end
    out_d.p_from_delta = res[0];
    out_d.q_from_delta = res[1];
    out_d.p_to_delta   = res[2];
    out_d.q_to_delta   = res[3];
    out_d.error_flag   = coef.zero | coef.sat | (|res_sat);
  end

  assign out_o.valid = v_q[NST-1];
  assign out_o.data  = out_q;

  // A configuration write must lower the item channel's ready right after the write.
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid && cfg_i.ready |=> !in_i.ready)
    else $error("item channel ready right after a configuration write");

  // A stalled result is neither dropped nor altered.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NST-1] && !out_o.ready |=> v_q[NST-1] && $stable(out_q))
    else $error("stalled result lost or changed");

  // An accepted beat occupies the first stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> v_q[0])
    else $error("accepted beat missing from the first stage");

  // Zero impedance always flags the result.
  a_zero_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && coef.zero |-> out_o.data.error_flag)
    else $error("zero impedance result without error flag");

endmodule
